@@ design/decision_tree_walk_core_macros.svh @@
// Assertion macros used by the walk sequencer of the decision tree walk core.
`ifndef DECISION_TREE_WALK_CORE_MACROS_SVH
`define DECISION_TREE_WALK_CORE_MACROS_SVH
`define DTW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ design/dtw_pkg.sv @@
// Package with shared types and constants of the decision tree walk core.
`timescale 1ns / 1ps
package dtw_pkg;
   localparam int NODE_DEPTH_DEF     = 4096;
   localparam int QUESTION_DEPTH_DEF = 512;
   localparam int VALUE_DEPTH_DEF    = 4096;
   localparam int FEATURE_COUNT_DEF  = 16;
   localparam int MAX_VALUES_DEF     = 64;
   localparam int WALK_LIMIT_DEF     = 128;

   localparam logic [2:0] FUNC_NODE     = 3'd0;
   localparam logic [2:0] FUNC_QUESTION = 3'd1;
   localparam logic [2:0] FUNC_VALUE    = 3'd2;
   localparam logic [2:0] FUNC_FEATURE  = 3'd3;
   localparam logic [2:0] FUNC_PREDICT  = 3'd4;

   localparam logic [1:0] ST_LEAF = 2'd0;
   localparam logic [1:0] ST_NULL = 2'd1;
   localparam logic [1:0] ST_OVER = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_NODE, S_QUEST, S_SCAN, S_LEAF, S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] leaf;
   } walk_done_type;
endpackage

@@ design/dtw_walker.sv @@
// Walk sequencer and memories of the decision tree walk core.
`timescale 1ns / 1ps
`include "decision_tree_walk_core_macros.svh"
module dtw_walker #(
   parameter int NODE_DEPTH     = dtw_pkg::NODE_DEPTH_DEF,
   parameter int QUESTION_DEPTH = dtw_pkg::QUESTION_DEPTH_DEF,
   parameter int VALUE_DEPTH    = dtw_pkg::VALUE_DEPTH_DEF,
   parameter int FEATURE_COUNT  = dtw_pkg::FEATURE_COUNT_DEF,
   parameter int MAX_VALUES     = dtw_pkg::MAX_VALUES_DEF,
   parameter int WALK_LIMIT     = dtw_pkg::WALK_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [12:0] node_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [11:0] req_index,
   input  logic        req_is_leaf,
   input  logic [11:0] req_yes_child,
   input  logic [11:0] req_no_child,
   input  logic [8:0]  req_question_index,
   input  logic [7:0]  req_feature_key,
   input  logic [6:0]  req_value_count,
   input  logic [11:0] req_value_start,
   input  logic [31:0] req_data_value,
   input  logic [31:0] req_mean_bits,
   input  logic [31:0] req_spread_bits,
   output logic        done_valid,
   input  logic        done_ready,
   output dtw_pkg::walk_done_type done_info,
   output logic [31:0] done_mean,
   output logic [31:0] done_spread
);
   import dtw_pkg::*;
   localparam int NW = $clog2(NODE_DEPTH);
   localparam int QW = (QUESTION_DEPTH > 1) ? $clog2(QUESTION_DEPTH) : 1;
   localparam int VW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
   localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
   localparam int SW = $clog2(WALK_LIMIT + 1);
   localparam int CW = $clog2(MAX_VALUES + 1);

   logic [33:0] node_mem [NODE_DEPTH];
   logic [63:0] leaf_mem [NODE_DEPTH];
   logic [26:0] quest_mem [QUESTION_DEPTH];
   logic [31:0] value_mem [VALUE_DEPTH];
   logic [31:0] feat_mem [FEATURE_COUNT];

   state_type   state_ff, state_in;
   logic [11:0] cur_ff, cur_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [12:0] slot_ff, slot_in;
   logic [CW-1:0] left_ff, left_in;
   logic [11:0] yes_ff, yes_in, no_ff, no_in;
   logic [1:0]  status_ff, status_in;
   logic [33:0] node_rd;
   logic [63:0] leaf_rd;
   logic [26:0] quest_rd;
   logic [31:0] value_rd;
   logic [31:0] feat_rd;
   logic [12:0] limit;
   logic        accept;
   logic [11:0] next_node;
   logic        quest_ok_ff, quest_ok_in;

   assign accept = req_valid && req_ready;
   assign limit = (32'(node_count) > NODE_DEPTH) ? 13'(NODE_DEPTH) : node_count;

   always_ff @(posedge clock) begin
      if (accept && req_func == FUNC_NODE && 32'(req_index) < NODE_DEPTH) begin
         node_mem[NW'(req_index)] <= {req_is_leaf, req_yes_child, req_no_child,
                                      req_question_index};
         leaf_mem[NW'(req_index)] <= {req_mean_bits, req_spread_bits};
      end
      if (accept && req_func == FUNC_QUESTION && 32'(req_index) < QUESTION_DEPTH)
         quest_mem[QW'(req_index)] <= {req_feature_key, req_value_count, req_value_start};
      if (accept && req_func == FUNC_VALUE && 32'(req_index) < VALUE_DEPTH)
         value_mem[VW'(req_index)] <= req_data_value;
      if (accept && req_func == FUNC_FEATURE && 32'(req_index) < FEATURE_COUNT)
         feat_mem[FW'(req_index)] <= req_data_value;
      node_rd  <= node_mem[NW'(cur_in)];
      leaf_rd  <= leaf_mem[NW'(cur_in)];
      quest_rd <= quest_mem[QW'(node_rd[8:0])];
      value_rd <= value_mem[VW'(slot_in)];
      feat_rd  <= feat_mem[FW'(quest_rd[26:19])];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff <= cur_in;
      steps_ff <= steps_in;
      slot_ff <= slot_in;
      left_ff <= left_in;
      yes_ff <= yes_in;
      no_ff <= no_in;
      status_ff <= status_in;
      quest_ok_ff <= quest_ok_in;
   end

   always_comb begin
      logic [7:0]  key;
      logic [6:0]  cnt;
      logic        hit;
      key = quest_rd[26:19];
      cnt = quest_rd[18:12];
      hit = 1'b0;
      state_in = state_ff;
      cur_in = cur_ff;
      steps_in = steps_ff;
      slot_in = slot_ff;
      left_in = left_ff;
      yes_in = yes_ff;
      no_in = no_ff;
      status_in = status_ff;
      quest_ok_in = quest_ok_ff;
      next_node = no_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_func == FUNC_PREDICT) begin
               cur_in = '0;
               steps_in = '0;
               if (limit == 13'd0) begin
                  status_in = ST_NULL;
                  state_in = S_DONE;
               end else begin
                  state_in = S_NODE;
               end
            end
         end
         S_NODE: begin
            yes_in = node_rd[32:21];
            no_in = node_rd[20:9];
            quest_ok_in = 32'(node_rd[8:0]) < QUESTION_DEPTH;
            if (node_rd[33]) begin
               status_in = ST_LEAF;
               state_in = S_LEAF;
            end else if (32'(steps_ff) >= WALK_LIMIT) begin
               status_in = ST_OVER;
               state_in = S_DONE;
            end else begin
               steps_in = steps_ff + 1'b1;
               state_in = S_QUEST;
            end
         end
         S_QUEST: begin
            slot_in = {1'b0, quest_rd[11:0]};
            left_in = (32'(cnt) > MAX_VALUES) ? CW'(MAX_VALUES) : CW'(cnt);
            if (!quest_ok_ff || 32'(key) >= FEATURE_COUNT || cnt == 7'd0) begin
               next_node = no_ff;
               state_in = S_NODE;
            end else begin
               state_in = S_SCAN;
            end
            if (state_in == S_NODE) begin
               cur_in = next_node;
               if (13'(next_node) >= limit) begin
                  status_in = ST_NULL;
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (32'(slot_ff) >= VALUE_DEPTH) begin
               hit = 1'b0;
               state_in = S_NODE;
            end else if (value_rd == feat_rd) begin
               hit = 1'b1;
               state_in = S_NODE;
            end else if (left_ff == CW'(1)) begin
               state_in = S_NODE;
            end else begin
               left_in = left_ff - 1'b1;
               slot_in = slot_ff + 1'b1;
            end
            if (state_in == S_NODE) begin
               next_node = hit ? yes_ff : no_ff;
               cur_in = next_node;
               if (13'(next_node) >= limit) begin
                  status_in = ST_NULL;
                  state_in = S_DONE;
               end
            end
         end
         S_LEAF: state_in = S_DONE;
         S_DONE: if (done_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic [31:0] mean_ff, spread_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_LEAF) begin
         mean_ff <= leaf_rd[63:32];
         spread_ff <= leaf_rd[31:0];
      end
   end

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      done_valid = (state_ff == S_DONE);
      done_info.status = status_ff;
      done_info.leaf = (status_ff == ST_LEAF) ? cur_ff : 12'd0;
      done_mean = (status_ff == ST_LEAF) ? mean_ff : 32'd0;
      done_spread = (status_ff == ST_LEAF) ? spread_ff : 32'd0;
   end

   `DTW_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, !done_valid, "ready while busy")
   `DTW_ASSERT_IMPL(a_steps, clock, reset, state_ff != S_IDLE, 32'(steps_ff) <= WALK_LIMIT,
                    "step count past limit")
   `DTW_ASSERT_NEXT(a_hold, clock, reset, done_valid && !done_ready, done_valid,
                    "result dropped")
endmodule

@@ design/dtw_out.sv @@
// Output register stage of the decision tree walk core.
`timescale 1ns / 1ps
module dtw_out (
   input  logic        clock,
   input  logic        reset,
   input  logic        done_valid,
   output logic        done_ready,
   input  dtw_pkg::walk_done_type done_info,
   input  logic [31:0] done_mean,
   input  logic [31:0] done_spread,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_mean,
   output logic [31:0] rsp_result_spread,
   output logic [11:0] rsp_leaf_node,
   output logic [1:0]  rsp_status
);
   import dtw_pkg::*;
   logic valid_ff, valid_in;
   logic [31:0] mean_ff, spread_ff;
   walk_done_type info_ff;

   assign done_ready = !valid_ff || rsp_ready;
   assign valid_in = done_valid ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (done_valid && done_ready) begin
         mean_ff <= done_mean;
         spread_ff <= done_spread;
         info_ff <= done_info;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_result_mean = mean_ff;
   assign rsp_result_spread = spread_ff;
   assign rsp_leaf_node = info_ff.leaf;
   assign rsp_status = info_ff.status;
endmodule

@@ design/decision_tree_walk_core.sv @@
// Top level of the decision tree walk core.
// Table writes are taken back to back while idle; a predict holds off new requests
// until its result enters the output register, reading each inner node, then its
// question, then scanning its values on the registered memory reads, and the leaf last.
// Reset clears the sequencer, output valid and node_count; tables stay undefined.
`timescale 1ns / 1ps
module decision_tree_walk_core #(
   parameter int NODE_DEPTH     = dtw_pkg::NODE_DEPTH_DEF,
   parameter int QUESTION_DEPTH = dtw_pkg::QUESTION_DEPTH_DEF,
   parameter int VALUE_DEPTH    = dtw_pkg::VALUE_DEPTH_DEF,
   parameter int FEATURE_COUNT  = dtw_pkg::FEATURE_COUNT_DEF,
   parameter int MAX_VALUES     = dtw_pkg::MAX_VALUES_DEF,
   parameter int WALK_LIMIT     = dtw_pkg::WALK_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_node_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [11:0] req_index,
   input  logic        req_is_leaf,
   input  logic [11:0] req_yes_child,
   input  logic [11:0] req_no_child,
   input  logic [8:0]  req_question_index,
   input  logic [7:0]  req_feature_key,
   input  logic [6:0]  req_value_count,
   input  logic [11:0] req_value_start,
   input  logic [31:0] req_data_value,
   input  logic [31:0] req_mean_bits,
   input  logic [31:0] req_spread_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_mean,
   output logic [31:0] rsp_result_spread,
   output logic [11:0] rsp_leaf_node,
   output logic [1:0]  rsp_status
);
   import dtw_pkg::*;
   logic [12:0] count_ff;
   logic done_valid, done_ready;
   walk_done_type done_info;
   logic [31:0] done_mean, done_spread;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_node_count;
      end
   end

   dtw_walker #(
      .NODE_DEPTH(NODE_DEPTH), .QUESTION_DEPTH(QUESTION_DEPTH),
      .VALUE_DEPTH(VALUE_DEPTH), .FEATURE_COUNT(FEATURE_COUNT),
      .MAX_VALUES(MAX_VALUES), .WALK_LIMIT(WALK_LIMIT)
   ) u_walker (
      .clock, .reset, .node_count(count_ff),
      .req_valid, .req_ready, .req_func, .req_index, .req_is_leaf,
      .req_yes_child, .req_no_child, .req_question_index, .req_feature_key,
      .req_value_count, .req_value_start, .req_data_value, .req_mean_bits,
      .req_spread_bits, .done_valid, .done_ready, .done_info, .done_mean,
      .done_spread
   );

   dtw_out u_out (
      .clock, .reset, .done_valid, .done_ready, .done_info, .done_mean,
      .done_spread, .rsp_valid, .rsp_ready, .rsp_result_mean,
      .rsp_result_spread, .rsp_leaf_node, .rsp_status
   );
endmodule
